// ===== src/mfd_pkg.sv =====
package mfd_pkg;

  // Frame geometry
  localparam int FRAME_BYTES_DEF = 11;
  localparam int STORE_DEPTH     = 9;
  localparam int POS_W           = 4;
  localparam int QUEUE_DEPTH_DEF = 2;

  // Byte positions inside a frame
  localparam int RANGE_POS = 5;
  localparam int FUNC_POS  = 6;
  localparam int SIGN_POS  = 8;

  localparam logic [7:0] ASCII_BASE = 8'h30;

  // Function bytes
  localparam logic [7:0] FN_DCV   = 8'h31;
  localparam logic [7:0] FN_ACV   = 8'h32;
  localparam logic [7:0] FN_MV    = 8'h33;
  localparam logic [7:0] FN_OHM   = 8'h34;
  localparam logic [7:0] FN_CAP   = 8'h35;
  localparam logic [7:0] FN_DEGC  = 8'h36;
  localparam logic [7:0] FN_UA    = 8'h37;
  localparam logic [7:0] FN_MA    = 8'h38;
  localparam logic [7:0] FN_AMP   = 8'h39;
  localparam logic [7:0] FN_BEEP  = 8'h3A;
  localparam logic [7:0] FN_DIODE = 8'h3B;
  localparam logic [7:0] FN_FREQ  = 8'h3C;
  localparam logic [7:0] FN_DEGF  = 8'h3D;

  // Marker bytes
  localparam logic [7:0] SIGN_NEG4  = 8'h34;
  localparam logic [7:0] SIGN_NEG5  = 8'h35;
  localparam logic [7:0] OPEN_MARK  = 8'h3A;
  localparam logic [7:0] DIGIT_MAX  = 8'h39;
  localparam logic [7:0] RANGE_ZERO = 8'h30;
  localparam logic [7:0] RANGE_LAST = 8'h37;

  typedef enum logic [4:0] {
    U_NONE = 5'd0,  U_V    = 5'd1,  U_MV   = 5'd2,  U_OHM = 5'd3,
    U_KOHM = 5'd4,  U_MOHM = 5'd5,  U_NF   = 5'd6,  U_UF  = 5'd7,
    U_MF   = 5'd8,  U_C    = 5'd9,  U_F    = 5'd10, U_UA  = 5'd11,
    U_MA   = 5'd12, U_A    = 5'd13, U_HZ   = 5'd14, U_KHZ = 5'd15,
    U_MHZ  = 5'd16
  } unit_t;

  typedef enum logic [2:0] {
    ST_VALUE    = 3'd0,
    ST_OOR      = 3'd1,
    ST_OPEN     = 3'd2,
    ST_HIGHR    = 3'd3,
    ST_BADRANGE = 3'd4,
    ST_UNKNOWN  = 3'd5
  } status_t;

  // Bytes of a complete frame that the decoder needs
  typedef struct packed {
    logic [4:0][7:0] digit_bytes;
    logic [7:0]      range_byte;
    logic [7:0]      func_byte;
    logic [7:0]      sign_byte;
  } frame_t;

  typedef struct packed {
    logic [2:0] digits;
    unit_t      unit;
  } fmt_t;

  typedef struct packed {
    logic [4:0][3:0] digit;
    logic [2:0]      integer_digits;
    logic            negative;
    unit_t           unit_code;
    status_t         status;
    logic [3:0]      function_code;
  } result_t;

  // Range format tables; digits of zero marks an undefined range
  function automatic fmt_t volts_fmt(input logic [2:0] r);
    fmt_t f;
    case (r)
      3'd1:    f = '{3'd1, U_V};
      3'd2:    f = '{3'd2, U_V};
      3'd3:    f = '{3'd3, U_V};
      3'd4:    f = '{3'd4, U_V};
      default: f = '{3'd0, U_NONE};
    endcase
    return f;
  endfunction

  function automatic fmt_t ohms_fmt(input logic [2:0] r);
    fmt_t f;
    case (r)
      3'd1:    f = '{3'd3, U_OHM};
      3'd2:    f = '{3'd1, U_KOHM};
      3'd3:    f = '{3'd2, U_KOHM};
      3'd4:    f = '{3'd3, U_KOHM};
      3'd5:    f = '{3'd1, U_MOHM};
      3'd6:    f = '{3'd2, U_MOHM};
      default: f = '{3'd0, U_NONE};
    endcase
    return f;
  endfunction

  function automatic fmt_t cap_fmt(input logic [2:0] r);
    fmt_t f;
    case (r)
      3'd1:    f = '{3'd2, U_NF};
      3'd2:    f = '{3'd3, U_NF};
      3'd3:    f = '{3'd1, U_UF};
      3'd4:    f = '{3'd2, U_UF};
      3'd5:    f = '{3'd3, U_UF};
      3'd6:    f = '{3'd1, U_MF};
      default: f = '{3'd0, U_NONE};
    endcase
    return f;
  endfunction

  function automatic fmt_t ua_fmt(input logic [2:0] r);
    fmt_t f;
    case (r)
      3'd0:    f = '{3'd3, U_UA};
      3'd1:    f = '{3'd4, U_UA};
      default: f = '{3'd0, U_NONE};
    endcase
    return f;
  endfunction

  function automatic fmt_t ma_fmt(input logic [2:0] r);
    fmt_t f;
    case (r)
      3'd0:    f = '{3'd2, U_MA};
      3'd1:    f = '{3'd3, U_MA};
      default: f = '{3'd0, U_NONE};
    endcase
    return f;
  endfunction

  function automatic fmt_t freq_fmt(input logic [2:0] r);
    fmt_t f;
    case (r)
      3'd0:    f = '{3'd2, U_HZ};
      3'd1:    f = '{3'd3, U_HZ};
      3'd2:    f = '{3'd1, U_KHZ};
      3'd3:    f = '{3'd2, U_KHZ};
      3'd4:    f = '{3'd3, U_KHZ};
      3'd5:    f = '{3'd1, U_MHZ};
      3'd6:    f = '{3'd2, U_MHZ};
      default: f = '{3'd3, U_MHZ};
    endcase
    return f;
  endfunction

endpackage

// ===== src/mfd_front.sv =====
module mfd_front #(
  parameter int FRAME_BYTES = mfd_pkg::FRAME_BYTES_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            byte_valid,
  input  logic [7:0]      rx_byte,
  input  logic            frame_start,
  output logic            frame_valid,
  output mfd_pkg::frame_t frame
);
  import mfd_pkg::*;

  localparam logic [POS_W-1:0] LAST_POS  = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] STORE_END = POS_W'(STORE_DEPTH);
  localparam logic [POS_W-1:0] SIGN_IDX  = POS_W'(SIGN_POS);

  logic [POS_W-1:0] byte_position;
  logic [POS_W-1:0] pos;
  logic [7:0]       frame_store [STORE_DEPTH];
  logic             last_byte;

  // frame_start restarts the position before the byte is placed
  assign pos       = frame_start ? '0 : byte_position;
  assign last_byte = (pos >= LAST_POS);

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position <= '0;
    end else if (byte_valid) begin
      byte_position <= last_byte ? '0 : pos + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (byte_valid && (pos < STORE_END)) begin
      frame_store[pos[$clog2(STORE_DEPTH)-1:0]] <= rx_byte;
    end
  end

  // Sign byte may be the one arriving now on a nine-byte frame
  always_comb begin
    for (int i = 0; i < 5; i++) begin
      frame.digit_bytes[i] = frame_store[i];
    end
    frame.range_byte = frame_store[RANGE_POS];
    frame.func_byte  = frame_store[FUNC_POS];
    frame.sign_byte  = (pos == SIGN_IDX) ? rx_byte : frame_store[SIGN_POS];
  end

  assign frame_valid = byte_valid && last_byte;

endmodule

// ===== src/mfd_queue.sv =====
module mfd_queue #(
  parameter int DEPTH = mfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  mfd_pkg::frame_t data_in,
  output logic            full,
  input  logic            pop,
  output logic            valid,
  output mfd_pkg::frame_t data_out
);
  import mfd_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

  frame_t           mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CNT_FULL);
  assign valid    = (count != '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;
  assign data_out = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= data_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_LAST) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_LAST) ? '0 : rd_ptr + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== src/mfd_back.sv =====
module mfd_back (
  input  logic             clk,
  input  logic             rst,
  input  logic             frame_valid,
  input  mfd_pkg::frame_t  frame,
  output logic             frame_take,
  output logic             res_valid,
  input  logic             res_take,
  output mfd_pkg::result_t res
);
  import mfd_pkg::*;

  result_t    dec;
  fmt_t       fmt;
  logic [7:0] rng;
  logic [7:0] fn;
  logic [7:0] sgn;
  logic [7:0] b0;
  logic [7:0] fn_off;
  logic [7:0] dig_off [5];
  logic [2:0] r;
  logic       rng_ok;
  logic       oor;
  logic       open_ckt;
  logic       sign4;
  logic       neg;
  logic [2:0] digits;
  unit_t      unit;
  status_t    status;

  assign rng      = frame.range_byte;
  assign fn       = frame.func_byte;
  assign sgn      = frame.sign_byte;
  assign b0       = frame.digit_bytes[0];
  assign r        = rng[2:0];
  assign rng_ok   = (rng >= RANGE_ZERO) && (rng <= RANGE_LAST);
  assign oor      = (b0 > DIGIT_MAX);
  assign open_ckt = (b0 == OPEN_MARK);
  assign sign4    = (sgn == SIGN_NEG4);
  assign fn_off   = fn - ASCII_BASE;

  always_comb begin
    digits = 3'd0;
    neg    = 1'b0;
    unit   = U_NONE;
    status = ST_VALUE;
    fmt    = '{3'd0, U_NONE};
    case (fn)
      FN_DCV, FN_ACV: begin
        fmt = volts_fmt(r);
        if (rng_ok && fmt.digits != 3'd0) begin
          digits = fmt.digits;
          unit   = fmt.unit;
          neg    = (fn == FN_DCV) && (sgn == SIGN_NEG5);
        end else begin
          status = ST_BADRANGE;
        end
      end
      FN_MV: begin
        digits = 3'd3;
        unit   = U_MV;
        neg    = sign4;
      end
      FN_OHM, FN_CAP: begin
        fmt = (fn == FN_OHM) ? ohms_fmt(r) : cap_fmt(r);
        if (oor) begin
          status = ST_OOR;
        end else if (rng_ok && fmt.digits != 3'd0) begin
          digits = fmt.digits;
          unit   = fmt.unit;
        end else begin
          status = ST_BADRANGE;
        end
      end
      FN_DEGC, FN_DEGF: begin
        unit = (fn == FN_DEGC) ? U_C : U_F;
        if (oor) begin
          status = ST_OOR;
        end else begin
          digits = 3'd4;
        end
      end
      FN_UA, FN_MA: begin
        fmt = (fn == FN_UA) ? ua_fmt(r) : ma_fmt(r);
        if (rng_ok && fmt.digits != 3'd0) begin
          digits = fmt.digits;
          unit   = fmt.unit;
          neg    = sign4;
        end else begin
          status = ST_BADRANGE;
        end
      end
      FN_AMP: begin
        digits = 3'd2;
        unit   = U_A;
        neg    = sign4;
      end
      FN_BEEP: begin
        if (open_ckt) begin
          status = ST_OPEN;
        end else if (rng == RANGE_ZERO) begin
          digits = 3'd3;
          unit   = U_OHM;
        end else begin
          status = ST_HIGHR;
        end
      end
      FN_DIODE: begin
        if (open_ckt) begin
          status = ST_OPEN;
        end else begin
          digits = 3'd1;
          unit   = U_MV;
        end
      end
      FN_FREQ: begin
        fmt = freq_fmt(r);
        if (rng_ok) begin
          digits = fmt.digits;
          unit   = fmt.unit;
        end else begin
          status = ST_BADRANGE;
        end
      end
      default: begin
        status = ST_UNKNOWN;
      end
    endcase
  end

  always_comb begin
    for (int i = 0; i < 5; i++) begin
      dig_off[i]   = frame.digit_bytes[i] - ASCII_BASE;
      dec.digit[i] = dig_off[i][3:0];
    end
    dec.integer_digits = (status == ST_VALUE) ? digits : 3'd0;
    dec.negative       = (status == ST_VALUE) && neg;
    dec.unit_code      = unit;
    dec.status         = status;
    dec.function_code  = fn_off[3:0];
  end

  // Output register refills in the same cycle it is drained
  assign frame_take = frame_valid && (!res_valid || res_take);

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (frame_take) begin
      res_valid <= 1'b1;
    end else if (res_take) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_take) begin
      res <= dec;
    end
  end

endmodule

// ===== src/multimeter_frame_decoder.sv =====
// Multimeter frame decoder. Bytes of a fixed-length ASCII frame (FRAME_BYTES
// long, 9..16) are pushed one per transfer; frame_start on a byte restarts
// the frame at position 0 and drops any partial frame. The last byte of a
// frame produces one result: five display digits, the number of integer
// digits, sign, unit code, status and function code. Other bytes produce
// nothing. Rate: one byte per cycle while full is low. A completed frame
// enters a frame queue (QUEUE_DEPTH entries) in the cycle its last byte is
// taken; the decoder drains one frame per cycle into a single result
// register while it is empty or being popped, so full rises only when
// results are not popped and the queue fills. Frames pass the queue, then
// the result register. Status codes other than zero force integer_digits
// and negative to zero; the digit fields always carry the frame's digits.
module multimeter_frame_decoder #(
  parameter int FRAME_BYTES = mfd_pkg::FRAME_BYTES_DEF,
  parameter int QUEUE_DEPTH = mfd_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  // byte input
  input  logic       push,
  output logic       full,
  input  logic [7:0] rx_byte,
  input  logic       frame_start,
  // result output
  output logic       empty,
  input  logic       pop,
  output logic [3:0] digit_a,
  output logic [3:0] digit_b,
  output logic [3:0] digit_c,
  output logic [3:0] digit_d,
  output logic [3:0] digit_e,
  output logic [2:0] integer_digits,
  output logic       negative,
  output logic [4:0] unit_code,
  output logic [2:0] status,
  output logic [3:0] function_code
);
  import mfd_pkg::*;

  logic    byte_in;      // byte transfer this cycle
  logic    f_valid;      // front completed a frame
  frame_t  f_frame;
  logic    q_full;
  logic    q_valid;
  frame_t  q_frame;
  logic    q_take;       // decoder takes the head frame
  logic    r_valid;
  logic    r_take;
  result_t r_data;

  assign full    = q_full;
  assign byte_in = push && !q_full;

  // Front: byte position and frame store
  mfd_front #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_front (
    .clk         (clk),
    .rst         (rst),
    .byte_valid  (byte_in),
    .rx_byte     (rx_byte),
    .frame_start (frame_start),
    .frame_valid (f_valid),
    .frame       (f_frame)
  );

  // Frame queue decouples collection from decode
  mfd_queue #(
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (f_valid),
    .data_in  (f_frame),
    .full     (q_full),
    .pop      (q_take),
    .valid    (q_valid),
    .data_out (q_frame)
  );

  // Back: decode and result register
  mfd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .frame_valid (q_valid),
    .frame       (q_frame),
    .frame_take  (q_take),
    .res_valid   (r_valid),
    .res_take    (r_take),
    .res         (r_data)
  );

  assign empty  = !r_valid;
  assign r_take = pop && r_valid;

  assign digit_a        = r_data.digit[0];
  assign digit_b        = r_data.digit[1];
  assign digit_c        = r_data.digit[2];
  assign digit_d        = r_data.digit[3];
  assign digit_e        = r_data.digit[4];
  assign integer_digits = r_data.integer_digits;
  assign negative       = r_data.negative;
  assign unit_code      = r_data.unit_code;
  assign status         = r_data.status;
  assign function_code  = r_data.function_code;

`ifndef SYNTH
  // Nothing waits on the result side right after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result pending after reset");

  // A frame pushed into the queue is visible to the decoder next cycle
  a_queue_holds: assert property (@(posedge clk) disable iff (rst)
    f_valid |=> q_valid)
    else $error("completed frame lost in queue");

  // Popping the only result with no frame queued leaves the output empty
  a_drain: assert property (@(posedge clk) disable iff (rst)
    (pop && !empty && !q_valid) |=> empty)
    else $error("result repeated after transfer");

  // A queued frame always moves on when the result register is free
  a_no_stall: assert property (@(posedge clk) disable iff (rst)
    (q_valid && empty) |=> !empty)
    else $error("decoder stalled with free result register");
`endif

endmodule
